// ===== hw/rtl/crcgc_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check package
// Item types, register indexes, operation codes and reset values shared by
// the CRC block and its checker.
// ----------------------------------------------------------------------------
package crcgc_pkg;

  // Largest generator degree that the remainder register can hold.
  localparam int unsigned MaxDegreeDefault = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_GEN_POLY   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_GEN_DEGREE = CfgIdxW'(1);

  localparam int unsigned GenPolyW   = 32;
  localparam int unsigned GenDegreeW = 6;

  localparam logic [GenPolyW-1:0]   GEN_POLY_RESET   = GenPolyW'(7);
  localparam logic [GenDegreeW-1:0] GEN_DEGREE_RESET = GenDegreeW'(8);

  // Operation of the item that closes a run.
  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_CHECK    = 1'b1;

  // Kind of a result item.
  localparam logic KIND_REMAINDER = 1'b0;
  localparam logic KIND_VERDICT   = 1'b1;

  typedef struct packed {
    logic op;
    logic data_bit;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic out_bit;
    logic accept;
    logic last_out;
  } out_item_t;

endpackage

// ===== hw/rtl/crc_generate_and_check.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check
// Bit-serial CRC with a configurable generator polynomial and degree.
// ----------------------------------------------------------------------------
// Results: a last item's first result shows in the cycle after it is taken;
//   remainder bits then leave one per cycle while the output is ready.
// Throughput: one input item per cycle. A last item waits while the previous
//   run has results waiting, unless its final one leaves in that cycle.
// Reset: rst_ni clears the remainder, result count and kind and restores the
//   generator registers to their reset values (polynomial 7, degree 8).
module crc_generate_and_check #(
  parameter int unsigned MAX_DEGREE = crcgc_pkg::MaxDegreeDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [crcgc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [crcgc_pkg::CfgDataW-1:0] cfg_data_i,
  // Input items: one stream bit each.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  crcgc_pkg::in_item_t            in_item_i,
  // Result items: remainder bits or a check verdict.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output crcgc_pkg::out_item_t           out_item_o
);

  // Effective degree and result counter hold values from 0 to MAX_DEGREE.
  localparam int unsigned DegW  = $clog2(MAX_DEGREE + 1);
  // The polynomial register is widened or trimmed to the remainder width.
  localparam int unsigned PolyW = (MAX_DEGREE > crcgc_pkg::GenPolyW) ?
                                  MAX_DEGREE : crcgc_pkg::GenPolyW;

  // --------------------------------------------------------------------------
  // Configuration registers. The port is always ready; writes to an index
  // beyond the register list are dropped.
  // --------------------------------------------------------------------------
  logic [crcgc_pkg::GenPolyW-1:0]   gen_poly_q;
  logic [crcgc_pkg::GenDegreeW-1:0] gen_degree_q;
  logic                             cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_poly_q   <= crcgc_pkg::GEN_POLY_RESET;
      gen_degree_q <= crcgc_pkg::GEN_DEGREE_RESET;
    end else if (cfg_fire) begin
      if (cfg_index_i == crcgc_pkg::REG_GEN_POLY) begin
        gen_poly_q <= cfg_data_i[crcgc_pkg::GenPolyW-1:0];
      end else if (cfg_index_i == crcgc_pkg::REG_GEN_DEGREE) begin
        gen_degree_q <= cfg_data_i[crcgc_pkg::GenDegreeW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Effective degree: a degree of zero acts as one, and a degree above the
  // remainder width acts as the full width. The mask keeps the remainder
  // bits below the degree.
  // --------------------------------------------------------------------------
  logic [DegW-1:0]       eff_deg;
  logic [MAX_DEGREE-1:0] deg_mask;
  logic [PolyW-1:0]      poly_wide;
  logic [MAX_DEGREE-1:0] poly_ext;

  always_comb begin
    if (gen_degree_q == '0) begin
      eff_deg = DegW'(1);
    end else if (int'(gen_degree_q) > int'(MAX_DEGREE)) begin
      eff_deg = DegW'(MAX_DEGREE);
    end else begin
      eff_deg = DegW'(gen_degree_q);
    end
  end

  always_comb begin
    for (int i = 0; i < int'(MAX_DEGREE); i++) begin
      deg_mask[i] = (i < int'(eff_deg));
    end
  end

  assign poly_wide = PolyW'(gen_poly_q);
  assign poly_ext  = poly_wide[MAX_DEGREE-1:0];

  // --------------------------------------------------------------------------
  // One step of modulo-2 long division per accepted item. The feedback is the
  // bit leaving the top of the remainder combined with the incoming stream
  // bit, which divides the stream as if degree zero bits were appended.
  // --------------------------------------------------------------------------
  logic [MAX_DEGREE-1:0] rem_q, rem_d;
  logic [MAX_DEGREE-1:0] rem_top_shr;
  logic [MAX_DEGREE-1:0] rem_step;
  logic                  feedback;
  logic                  in_fire;
  logic                  out_fire;
  logic                  busy;

  assign rem_top_shr = rem_q >> (eff_deg - DegW'(1));
  assign feedback    = rem_top_shr[0] ^ in_item_i.data_bit;
  assign rem_step    = ((rem_q << 1) & deg_mask) ^
                       (feedback ? (poly_ext & deg_mask) : '0);

  // Items that do not close a run only touch the remainder, so they flow
  // while the result stage drains. A last item needs the result stage free,
  // or the final result of the previous run leaving in the same cycle.
  assign in_ready_o = !(busy && in_item_i.last) || (out_fire && out_item_o.last_out);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    rem_d = rem_q;
    if (in_fire) begin
      // The remainder starts over after the last item of a run.
      rem_d = in_item_i.last ? '0 : rem_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result stage. On the last item of a generate run the final remainder is
  // loaded left aligned into a shift register and leaves most significant
  // bit first, one item per cycle while the output is ready; the counter
  // holds the items left. A check run loads a single verdict item instead.
  // A new run loading as the previous run's final item leaves takes over.
  // --------------------------------------------------------------------------
  logic [MAX_DEGREE-1:0] emit_q, emit_d;
  logic [DegW-1:0]       cnt_q, cnt_d;
  logic                  kind_q, kind_d;
  logic                  acc_q, acc_d;

  assign busy     = (cnt_q != '0);
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    emit_d = emit_q;
    cnt_d  = cnt_q;
    kind_d = kind_q;
    acc_d  = acc_q;
    if (in_fire && in_item_i.last) begin
      if (in_item_i.op == crcgc_pkg::OP_CHECK) begin
        kind_d = crcgc_pkg::KIND_VERDICT;
        acc_d  = (rem_step == '0);
        cnt_d  = DegW'(1);
      end else begin
        kind_d = crcgc_pkg::KIND_REMAINDER;
        emit_d = rem_step << (DegW'(MAX_DEGREE) - eff_deg);
        cnt_d  = eff_deg;
      end
    end else if (out_fire) begin
      emit_d = emit_q << 1;
      cnt_d  = cnt_q - DegW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      kind_q <= crcgc_pkg::KIND_REMAINDER;
    end else begin
      cnt_q  <= cnt_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_q <= emit_d;
    acc_q  <= acc_d;
  end

  assign out_valid_o         = busy;
  assign out_item_o.kind     = kind_q;
  assign out_item_o.out_bit  = (kind_q == crcgc_pkg::KIND_REMAINDER) &&
                               emit_q[MAX_DEGREE-1];
  assign out_item_o.accept   = (kind_q == crcgc_pkg::KIND_VERDICT) && acc_q;
  assign out_item_o.last_out = (cnt_q == DegW'(1));

endmodule

// ===== hw/rtl/crcgc_checker.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check port checker
// Watches the top level ports for result ordering and handshake behavior.
// ----------------------------------------------------------------------------
module crcgc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input crcgc_pkg::in_item_t            in_item_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input crcgc_pkg::out_item_t           out_item_o
);

  logic in_last_fire;

  assign in_last_fire = in_valid_i && in_ready_o && in_item_i.last;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // A verdict is always the single and final item of its run.
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == crcgc_pkg::KIND_VERDICT) |->
    out_item_o.last_out)
    else $error("verdict item not flagged as final");

  // Remainder bits of one run follow each other without a gap.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last_out |=> out_valid_o)
    else $error("gap inside a run of result items");

  // A last item always produces a result in the next cycle.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_fire |=> out_valid_o)
    else $error("last item produced no result");

  // Without a pending run or a last item, no result appears.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_last_fire |=> !out_valid_o)
    else $error("result item without a closing last item");

endmodule

bind crc_generate_and_check crcgc_checker u_crcgc_checker (.*);

// ===== sim/tb_crc_generate_and_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for crc_generate_and_check
// Streams serial message and codeword bits through the CRC block under a
// series of generator settings. A cycle-level predictor tracks the remainder,
// and every result item is checked field by field against its prediction.
// ----------------------------------------------------------------------------
module tb_crc_generate_and_check;

  localparam int unsigned MAX_DEG = crcgc_pkg::MaxDegreeDefault;
  // Quiet cycles after the last result before touching the registers or
  // ending the run; covers the longest remainder drain with margin.
  localparam int unsigned SETTLE_CYCLES = MAX_DEG + 8;
  // Cycles with no handshake on any channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned IDLE_PCT = 27;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned N_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 38;

  // Register indexes past the end of the map; writes there must be dropped.
  localparam logic [crcgc_pkg::CfgIdxW-1:0] REG_UNUSED_LO = crcgc_pkg::CfgIdxW'(2);
  localparam logic [crcgc_pkg::CfgIdxW-1:0] REG_UNUSED_HI = crcgc_pkg::CfgIdxW'(3);

  typedef enum int {
    MSG_GENERATE,  // random message closed in generate mode
    MSG_CODEWORD,  // message followed by its own CRC, closed in check mode
    MSG_CORRUPT,   // same as a codeword, with one bit flipped
    MSG_NOISE,     // random bits, random closing mode
    MSG_OPEN       // random bits with no closing item at all
  } msg_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [crcgc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [crcgc_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  crcgc_pkg::in_item_t            in_item = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  crcgc_pkg::out_item_t           out_item;

  crc_generate_and_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #6 clk_i = ~clk_i;

  // Stream bits waiting to be offered, and result items predicted but not
  // yet seen on the output.
  crcgc_pkg::in_item_t  bit_send_q[$];
  crcgc_pkg::out_item_t crc_result_q[$];

  // The testbench's own copy of the generator registers and of the remainder.
  logic [crcgc_pkg::GenPolyW-1:0]   poly_reg = crcgc_pkg::GEN_POLY_RESET;
  logic [crcgc_pkg::GenDegreeW-1:0] degree_reg = crcgc_pkg::GEN_DEGREE_RESET;
  logic [MAX_DEG-1:0]               crc_rem = '0;

  logic        in_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned queued_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_bits = 0;
  int unsigned n_results = 0;
  int unsigned n_gen_runs = 0;
  int unsigned n_accepts = 0;
  int unsigned n_rejects = 0;

  // Degree zero behaves as one, and anything beyond the register width
  // behaves as the full width.
  function automatic int unsigned eff_degree(logic [crcgc_pkg::GenDegreeW-1:0] deg);
    if (deg == 0) return 1;
    if (deg > MAX_DEG) return MAX_DEG;
    return deg;
  endfunction

  // One step of modulo-2 long division: shift the remainder left and fold
  // in the generator whenever the bit leaving the top differs from the data.
  function automatic logic [MAX_DEG-1:0] crc_advance(logic [MAX_DEG-1:0] rem,
                                                     logic b,
                                                     logic [crcgc_pkg::GenPolyW-1:0] poly,
                                                     int unsigned d);
    logic [MAX_DEG-1:0] mask;
    logic [MAX_DEG-1:0] nxt;
    mask = (d >= MAX_DEG) ? '1 : ((MAX_DEG'(1) << d) - 1'b1);
    nxt = (rem << 1) & mask;
    if (rem[d-1] ^ b) nxt ^= MAX_DEG'(poly) & mask;
    return nxt;
  endfunction

  // Advance the remainder for an accepted bit and, on a closing bit, queue
  // either the remainder bits or the single verdict.
  task automatic crc_predict(crcgc_pkg::in_item_t it);
    int unsigned          d;
    crcgc_pkg::out_item_t r;
    d = eff_degree(degree_reg);
    crc_rem = crc_advance(crc_rem, it.data_bit, poly_reg, d);
    if (it.last) begin
      if (it.op == crcgc_pkg::OP_GENERATE) begin
        n_gen_runs++;
        for (int k = 0; k < int'(d); k++) begin
          r.kind     = crcgc_pkg::KIND_REMAINDER;
          r.out_bit  = crc_rem[int'(d) - 1 - k];
          r.accept   = 1'b0;
          r.last_out = (k == int'(d) - 1);
          crc_result_q.push_back(r);
        end
      end else begin
        r.kind     = crcgc_pkg::KIND_VERDICT;
        r.out_bit  = 1'b0;
        r.accept   = (crc_rem == '0);
        r.last_out = 1'b1;
        if (r.accept) n_accepts++;
        else n_rejects++;
        crc_result_q.push_back(r);
      end
      crc_rem = '0;
    end
  endtask

  task automatic report_mismatch(string what, crcgc_pkg::out_item_t want,
                                 crcgc_pkg::out_item_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%0t: %s: expected kind=%b bit=%b accept=%b last=%b,",
               $realtime, what, want.kind, want.out_bit, want.accept, want.last_out);
      $display("    got kind=%b bit=%b accept=%b last=%b",
               got.kind, got.out_bit, got.accept, got.last_out);
    end
  endtask

  // Driver: offers the next stream bit at the falling edge once the current
  // one has gone, and sets the output ready. Both sides idle at random
  // unless a calm stretch is in force.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (bit_send_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_item  <= bit_send_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: samples all handshakes at the rising edge, feeds the predictor,
  // checks results in order, and watches for a hung block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        n_bits++;
        crc_predict(in_item);
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (crc_result_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_item);
        end else if (out_item.kind != crc_result_q[0].kind ||
                     out_item.out_bit != crc_result_q[0].out_bit ||
                     out_item.accept != crc_result_q[0].accept ||
                     out_item.last_out != crc_result_q[0].last_out) begin
          report_mismatch("result mismatch", crc_result_q.pop_front(), out_item);
        end else begin
          void'(crc_result_q.pop_front());
        end
      end
      if (in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results pending",
                 STALL_LIMIT, crc_result_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Register write; valid stays high across back-to-back writes and the
  // caller lowers it once the burst is done.
  task automatic write_reg(logic [crcgc_pkg::CfgIdxW-1:0] idx,
                           logic [crcgc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == crcgc_pkg::REG_GEN_POLY) poly_reg = data[crcgc_pkg::GenPolyW-1:0];
    else if (idx == crcgc_pkg::REG_GEN_DEGREE) degree_reg = data[crcgc_pkg::GenDegreeW-1:0];
  endtask

  // Program a generator. Upper bits of the degree word are random so that
  // truncation to the register width is exercised, and writes to unused
  // indexes are mixed in to show they change nothing.
  task automatic set_generator(logic [crcgc_pkg::GenPolyW-1:0] poly,
                               logic [crcgc_pkg::GenDegreeW-1:0] deg);
    write_reg(crcgc_pkg::REG_GEN_POLY, poly);
    write_reg(REG_UNUSED_LO, $urandom);
    write_reg(crcgc_pkg::REG_GEN_DEGREE,
              (crcgc_pkg::CfgDataW'($urandom) & ~crcgc_pkg::CfgDataW'(6'h3F)) |
              crcgc_pkg::CfgDataW'(deg));
    write_reg(REG_UNUSED_HI, $urandom);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_bit(logic op, logic b, logic is_last);
    crcgc_pkg::in_item_t it;
    it.op       = op;
    it.data_bit = b;
    it.last     = is_last;
    bit_send_q.push_back(it);
    queued_items++;
  endtask

  // Build one message. Codewords carry the CRC of their message under the
  // current generator, so a clean one must be accepted. Ops on all bits
  // but the closing one are random, since only the closing op matters.
  task automatic queue_message(msg_kind_e kind, int unsigned len);
    logic               bits[$];
    logic [MAX_DEG-1:0] plan;
    int unsigned        d;
    int unsigned        pos;
    logic               final_op;
    logic               is_last;
    d = eff_degree(degree_reg);
    plan = '0;
    for (int i = 0; i < int'(len); i++) begin
      bits.push_back(1'($urandom));
      plan = crc_advance(plan, bits[i], poly_reg, d);
    end
    if (kind == MSG_CODEWORD || kind == MSG_CORRUPT) begin
      for (int k = int'(d) - 1; k >= 0; k--) bits.push_back(plan[k]);
    end
    if (kind == MSG_CORRUPT) begin
      pos = $urandom_range(0, bits.size() - 1);
      bits[pos] = ~bits[pos];
    end
    if (kind == MSG_GENERATE) final_op = crcgc_pkg::OP_GENERATE;
    else if (kind == MSG_NOISE) final_op = 1'($urandom);
    else final_op = crcgc_pkg::OP_CHECK;
    for (int i = 0; i < bits.size(); i++) begin
      is_last = (kind != MSG_OPEN) && (i == bits.size() - 1);
      push_bit(is_last ? final_op : 1'($urandom), bits[i], is_last);
    end
  endtask

  // Wait until every bit is in and every predicted result is out, then give
  // the block time to finish any drain before the registers change.
  task automatic wait_settled();
    do @(posedge clk_i);
    while (bit_send_q.size() != 0 || in_valid || crc_result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [crcgc_pkg::GenPolyW-1:0]   phase_poly[N_PHASES];
    logic [crcgc_pkg::GenDegreeW-1:0] phase_deg[N_PHASES];
    int unsigned                      target;
    int unsigned                      pick;
    msg_kind_e                        kind;

    // Settings run from the widest degree with a dense generator down to
    // degree one, through out-of-range degree words, and back to reset values.
    phase_poly[0] = '1;               phase_deg[0] = 6'd32;
    phase_poly[1] = '0;               phase_deg[1] = 6'd1;
    phase_poly[2] = $urandom;         phase_deg[2] = 6'd0;
    phase_poly[3] = 32'h04C1_1DB7;    phase_deg[3] = 6'd63;
    phase_poly[4] = 32'h0000_1021;    phase_deg[4] = 6'd16;
    phase_poly[5] = $urandom;         phase_deg[5] = 6'($urandom_range(1, MAX_DEG));
    phase_poly[6] = crcgc_pkg::GEN_POLY_RESET;
    phase_deg[6]  = crcgc_pkg::GEN_DEGREE_RESET;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset generator: a lone one in generate mode,
    // a lone zero checked (accepted), a lone one checked (rejected), an
    // all-zero message whose inner ops disagree with the closing op, and a
    // short clean codeword.
    push_bit(crcgc_pkg::OP_GENERATE, 1'b1, 1'b1);
    push_bit(crcgc_pkg::OP_CHECK, 1'b0, 1'b1);
    push_bit(crcgc_pkg::OP_CHECK, 1'b1, 1'b1);
    push_bit(crcgc_pkg::OP_GENERATE, 1'b0, 1'b0);
    push_bit(crcgc_pkg::OP_CHECK, 1'b0, 1'b0);
    push_bit(crcgc_pkg::OP_GENERATE, 1'b0, 1'b1);
    queue_message(MSG_CODEWORD, 4);
    wait_settled();

    // Random part, one phase per generator setting. The sender holds off at
    // each boundary until every result is in. All but the last phase stop in
    // the middle of a message, so the next setting picks up a half-divided
    // remainder; the first message of each phase closes it in generate mode.
    for (int p = 0; p < N_PHASES; p++) begin
      set_generator(phase_poly[p], phase_deg[p]);
      calm = (p == 0);
      target = queued_items + PHASE_ITEMS;
      queue_message(MSG_GENERATE, $urandom_range(1, 6));
      while (queued_items < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) kind = MSG_GENERATE;
        else if (pick < 6) kind = MSG_CODEWORD;
        else if (pick < 8) kind = MSG_CORRUPT;
        else kind = MSG_NOISE;
        queue_message(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                          : $urandom_range(1, 16));
      end
      if (p != N_PHASES - 1) queue_message(MSG_OPEN, $urandom_range(1, 6));
      wait_settled();
      calm = 1'b0;
    end

    $display("Run covered %0d stream bits under %0d generator settings: %0d generate runs,",
             n_bits, N_PHASES + 1, n_gen_runs);
    $display("%0d check runs (%0d accepted, %0d rejected), %0d result items, %0d errors.",
             n_accepts + n_rejects, n_accepts, n_rejects, n_results, n_errors);
    if (n_errors == 0 && crc_result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
